// ===== design/obrw_pkg.sv =====
// Shared types and constants for the ordered batch ring writer.
// No dependencies; used by every module of the block except obrw_ram.
`timescale 1ns / 1ps

package obrw_pkg;

    localparam int CAPACITY      = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int RING_AW       = $clog2(CAPACITY);
    localparam int ENTRY_W       = 64 + PAYLOAD_WIDTH;
    localparam int FREE_W        = 7;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_COMMIT = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD        = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_ORDER      = 3'd3,
        ST_INCOMPLETE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_READ   = 2'd2,
        S_REPORT = 2'd3
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic apply_begin;
        logic report;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;
        logic out_free;
    } sts_t;

endpackage

// ===== design/obrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module obrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/obrw_ctrl.sv =====
// Sequencer for the ring writer: accept, execute, optional floor read, report.
// Depends on obrw_pkg.
`timescale 1ns / 1ps

module obrw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  obrw_pkg::sts_t sts,
    output obrw_pkg::cmd_t cmd
);

    obrw_pkg::ctrl_state_t state_reg;
    obrw_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obrw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            obrw_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = obrw_pkg::S_EXEC;
                end
            end
            obrw_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                // a successful begin needs the ram word below the write index
                state_next = sts.need_read ? obrw_pkg::S_READ : obrw_pkg::S_REPORT;
            end
            obrw_pkg::S_READ:
            begin
                cmd.apply_begin = 1'b1;
                state_next      = obrw_pkg::S_REPORT;
            end
            obrw_pkg::S_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = obrw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = obrw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/obrw_datapath.sv =====
// Ring writer datapath: input registers, batch state, counters, entry ram
// and the result register. Depends on obrw_pkg and obrw_ram.
`timescale 1ns / 1ps

module obrw_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  obrw_pkg::cmd_t cmd,
    output obrw_pkg::sts_t sts,
    input  logic [1:0]     in_kind,
    input  logic [15:0]    in_batch_count,
    input  logic [63:0]    in_entry_time,
    input  logic [31:0]    in_entry_payload,
    input  logic [31:0]    in_read_index,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           accepted,
    output logic [2:0]     status,
    output logic [6:0]     free_slots,
    output logic [31:0]    write_index_out,
    output logic [31:0]    overflow_total,
    output logic [31:0]    order_failure_total
);

    localparam int AW = obrw_pkg::RING_AW;

    // captured item
    obrw_pkg::kind_t kind_reg;
    logic [15:0]     count_reg;
    logic [63:0]     time_reg;
    logic [31:0]     payload_reg;
    logic [31:0]     rd_reg;

    // ring state
    logic [31:0] write_index_reg, write_index_next;
    logic        batch_open_reg, batch_open_next;
    logic [31:0] batch_base_reg, batch_base_next;
    logic [15:0] batch_size_reg, batch_size_next;
    logic [15:0] batch_written_reg, batch_written_next;
    logic [63:0] time_floor_reg, time_floor_next;
    logic [31:0] overflow_reg, overflow_next;
    logic [31:0] order_fail_reg, order_fail_next;
    obrw_pkg::status_t status_reg, status_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        res_accepted_reg;
    logic [2:0]  res_status_reg;
    logic [6:0]  res_free_reg;
    logic [31:0] res_wi_reg;
    logic [31:0] res_ovf_reg;
    logic [31:0] res_ord_reg;

    logic [31:0] used;
    logic        begin_bad;
    logic        begin_ovf;
    logic        append_bad;
    logic        append_order;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [obrw_pkg::ENTRY_W-1:0] ram_wdata;
    logic [obrw_pkg::ENTRY_W-1:0] ram_rdata;
    logic [obrw_pkg::FREE_W-1:0]  free_now;

    assign used = write_index_reg - rd_reg;

    assign begin_bad = (count_reg == 16'd0)
                    || ({1'b0, count_reg} > 17'(obrw_pkg::CAPACITY));
    assign begin_ovf = ({1'b0, used} + {17'd0, count_reg}) > 33'(obrw_pkg::CAPACITY);

    assign append_bad   = !batch_open_reg || (batch_written_reg >= batch_size_reg);
    assign append_order = time_reg < time_floor_reg;

    assign free_now = (used < 32'(obrw_pkg::CAPACITY))
                    ? obrw_pkg::FREE_W'(32'(obrw_pkg::CAPACITY) - used)
                    : '0;

    assign sts.need_read = (kind_reg == obrw_pkg::KIND_BEGIN) && !begin_bad && !begin_ovf;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // entry ram: time in the low bits, payload above
    assign ram_we    = cmd.exec && (kind_reg == obrw_pkg::KIND_APPEND)
                    && !append_bad && !append_order;
    assign ram_waddr = batch_base_reg[AW-1:0] + batch_written_reg[AW-1:0];
    assign ram_wdata = {payload_reg[obrw_pkg::PAYLOAD_WIDTH-1:0], time_reg};
    assign ram_raddr = AW'(write_index_reg - 32'd1);

    obrw_ram #(
        .WIDTH (obrw_pkg::ENTRY_W),
        .DEPTH (obrw_pkg::CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg    <= obrw_pkg::kind_t'(in_kind);
            count_reg   <= in_batch_count;
            time_reg    <= in_entry_time;
            payload_reg <= in_entry_payload;
            rd_reg      <= in_read_index;
        end
        if (cmd.report)
        begin
            res_accepted_reg <= (status_reg == obrw_pkg::ST_OK);
            res_status_reg   <= status_reg;
            res_free_reg     <= free_now;
            res_wi_reg       <= write_index_reg;
            res_ovf_reg      <= overflow_reg;
            res_ord_reg      <= order_fail_reg;
        end
    end

    always_comb
    begin
        write_index_next   = write_index_reg;
        batch_open_next    = batch_open_reg;
        batch_base_next    = batch_base_reg;
        batch_size_next    = batch_size_reg;
        batch_written_next = batch_written_reg;
        time_floor_next    = time_floor_reg;
        overflow_next      = overflow_reg;
        order_fail_next    = order_fail_reg;
        status_next        = status_reg;

        if (cmd.exec)
        begin
            case (kind_reg)
                obrw_pkg::KIND_BEGIN:
                begin
                    if (begin_bad)
                    begin
                        status_next = obrw_pkg::ST_BAD;
                    end
                    else if (begin_ovf)
                    begin
                        overflow_next = overflow_reg + 32'd1;
                        status_next   = obrw_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        status_next = obrw_pkg::ST_OK;
                    end
                end
                obrw_pkg::KIND_APPEND:
                begin
                    if (append_bad)
                    begin
                        status_next = obrw_pkg::ST_BAD;
                    end
                    else if (append_order)
                    begin
                        order_fail_next = order_fail_reg + 32'd1;
                        status_next     = obrw_pkg::ST_ORDER;
                    end
                    else
                    begin
                        time_floor_next    = time_reg;
                        batch_written_next = batch_written_reg + 16'd1;
                        status_next        = obrw_pkg::ST_OK;
                    end
                end
                obrw_pkg::KIND_COMMIT:
                begin
                    if (!batch_open_reg)
                    begin
                        status_next = obrw_pkg::ST_BAD;
                    end
                    else if (batch_written_reg != batch_size_reg)
                    begin
                        status_next = obrw_pkg::ST_INCOMPLETE;
                    end
                    else
                    begin
                        write_index_next = batch_base_reg + {16'd0, batch_size_reg};
                        batch_open_next  = 1'b0;
                        status_next      = obrw_pkg::ST_OK;
                    end
                end
                obrw_pkg::KIND_ABORT:
                begin
                    batch_open_next = 1'b0;
                    status_next     = obrw_pkg::ST_OK;
                end
                default:
                begin
                    status_next = obrw_pkg::ST_BAD;
                end
            endcase
        end

        if (cmd.apply_begin)
        begin
            // floor from the last published entry, zero on an empty ring
            time_floor_next    = (write_index_reg != rd_reg) ? ram_rdata[63:0] : 64'd0;
            batch_open_next    = 1'b1;
            batch_base_next    = write_index_reg;
            batch_size_next    = count_reg;
            batch_written_next = 16'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg   <= '0;
            batch_open_reg    <= 1'b0;
            batch_base_reg    <= '0;
            batch_size_reg    <= '0;
            batch_written_reg <= '0;
            time_floor_reg    <= '0;
            overflow_reg      <= '0;
            order_fail_reg    <= '0;
            status_reg        <= obrw_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            write_index_reg   <= write_index_next;
            batch_open_reg    <= batch_open_next;
            batch_base_reg    <= batch_base_next;
            batch_size_reg    <= batch_size_next;
            batch_written_reg <= batch_written_next;
            time_floor_reg    <= time_floor_next;
            overflow_reg      <= overflow_next;
            order_fail_reg    <= order_fail_next;
            status_reg        <= status_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = res_accepted_reg;
    assign status              = res_status_reg;
    assign free_slots          = res_free_reg;
    assign write_index_out     = res_wi_reg;
    assign overflow_total      = res_ovf_reg;
    assign order_failure_total = res_ord_reg;

endmodule

// ===== design/ordered_batch_ring_writer_unit.sv =====
// Top level of the ordered batch ring writer.
// Depends on obrw_pkg, obrw_ctrl, obrw_datapath (and obrw_ram below it).
`timescale 1ns / 1ps

// Producer side of a 64-entry ring of timestamped commands, filled in batches.
// Slave stream: one item per operation; tuser carries the kind (begin, append,
//   commit, abort), tdata the batch count, entry time, payload and the
//   consumer's free-running read index.
// Master stream: one result item per operation: accepted flag, status code,
//   free slots, published write index and the overflow / order-failure counts.
// Sequence: an item is taken in the idle state, executed in the exec state and
//   its result loaded into the output register in the report state (a begin
//   that opens a batch passes through the read state between exec and report,
//   for the registered ram read of the last published entry's timestamp).
//   The sequencer handles one item at a time: it takes no new item until the
//   last one's result has been loaded into the output register.
// The output register holds a finished result while the next item is taken
//   and executed; if the receiver still holds tready low when that next result
//   is ready, the sequencer waits in its report state and tready stays low.
// Reset (rst_n low, asynchronous) clears the write index, batch state, time
//   floor and both counters and empties the output register. The entry ram
//   is not cleared; only published entries are ever read back.
module ordered_batch_ring_writer_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] batch_count, [79:16] entry_time, [111:80] entry_payload,
    // [143:112] read_index
    input  logic [143:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] accepted, [3:1] status, [10:4] free_slots, [42:11] write_index_out,
    // [74:43] overflow_total, [106:75] order_failure_total, [111:107] zero
    output logic [111:0] m_axis_tdata
);

    obrw_pkg::cmd_t cmd;
    obrw_pkg::sts_t sts;

    logic        res_accepted;
    logic [2:0]  res_status;
    logic [6:0]  res_free;
    logic [31:0] res_wi;
    logic [31:0] res_ovf;
    logic [31:0] res_ord;

    obrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    obrw_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_kind             (s_axis_tuser),
        .in_batch_count      (s_axis_tdata[15:0]),
        .in_entry_time       (s_axis_tdata[79:16]),
        .in_entry_payload    (s_axis_tdata[111:80]),
        .in_read_index       (s_axis_tdata[143:112]),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .accepted            (res_accepted),
        .status              (res_status),
        .free_slots          (res_free),
        .write_index_out     (res_wi),
        .overflow_total      (res_ovf),
        .order_failure_total (res_ord)
    );

    assign m_axis_tdata = {5'd0, res_ord, res_ovf, res_wi, res_free, res_status, res_accepted};

endmodule
